// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define WBPS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wbps assertion failed");
`define WBPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wbps assertion failed");
`else
`define WBPS_ASSERT(lbl, clk, rst, prop)
`define WBPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/wbps_pkg.sv =====
package wbps_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int BYTE_W      = 8;
  localparam int OFFSET_BITS = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  // request actions
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD_VALUE = 1'b1;

  localparam logic [LEN_W-1:0]       LEN_RESET  = LEN_W'(1);
  localparam logic [LEN_W-1:0]       LEN_MAX    = LEN_W'(MAX_PATTERN);
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] byte_row_t;

  typedef struct packed {
    logic                action;
    logic [IDX_W-1:0]    pattern_index;
    logic [BYTE_W-1:0]   byte_value;
    logic                region_last;
  } in_item_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } pat_wr_t;

endpackage

// ===== rtl/wbps_if.sv =====
interface wbps_in_if;
  import wbps_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [IDX_W-1:0]  pattern_index;
  logic [BYTE_W-1:0] byte_value;
  logic              region_last;

  modport source (output valid, action, pattern_index, byte_value, region_last, input ready);
  modport sink   (input valid, action, pattern_index, byte_value, region_last, output ready);
endinterface

interface wbps_out_if;
  import wbps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [OFFSET_BITS-1:0] match_offset;

  modport source (output valid, found, match_offset, input ready);
  modport sink   (input valid, found, match_offset, output ready);
endinterface

// ===== rtl/wbps_pattern_store.sv =====
module wbps_pattern_store (
  input  logic              clk,
  input  wbps_pkg::pat_wr_t wr,
  output wbps_pkg::byte_row_t pattern
);
  import wbps_pkg::*;

  byte_row_t store;

  // contents are undefined until written, so no reset
  always_ff @(posedge clk) begin
    if (wr.en) begin
      store[wr.addr] <= wr.data;
    end
  end

  assign pattern = store;

endmodule

// ===== rtl/wbps_matcher.sv =====
module wbps_matcher (
  input  wbps_pkg::byte_row_t          pattern,
  input  wbps_pkg::byte_row_t          window,
  input  logic [wbps_pkg::LEN_W-1:0]   len,
  input  logic [wbps_pkg::BYTE_W-1:0]  wildcard_value,
  output logic                         hit
);
  import wbps_pkg::*;

  logic [LEN_W-1:0]       shamt;
  byte_row_t              aligned;
  logic [MAX_PATTERN-1:0] lane_ok;

  // slide the window so that its oldest byte in use lands on the top lane
  assign shamt   = LEN_MAX - len;
  assign aligned = window << {shamt, 3'b000};

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      lane_ok[i] = (LEN_W'(i) >= len) || (pattern[i] == wildcard_value) ||
                   (pattern[i] == aligned[MAX_PATTERN-1-i]);
    end
  end

  assign hit = &lane_ok;

endmodule

// ===== rtl/wildcard_byte_pattern_search.sv =====
// A request accepted into the input register moves on to the result register when the
// stage advances, which waits while a held result is not yet taken by result.ready.
// Throughput: one request per cycle unless a pending result is held back by result.ready.
// Reset (synchronous, rst high): clears the data window, byte count and region state,
// sets pattern_length to 1 and wildcard_value to 0; the pattern store is not cleared.
`include "assert_macros.svh"

module wildcard_byte_pattern_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data,
  wbps_in_if.sink                             item,
  wbps_out_if.source                          result
);
  import wbps_pkg::*;

  // Configuration registers
  logic [LEN_W-1:0]  pattern_length;
  logic [BYTE_W-1:0] wildcard_value;

  // Input register
  logic     s1_valid;
  in_item_t s1;

  // Region state
  byte_row_t              window;
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   region_done;

  // Result register
  logic                   out_valid;
  logic                   out_found;
  logic [OFFSET_BITS-1:0] out_offset;

  // Stage logic
  logic                   advance;
  logic                   is_search;
  logic                   live;
  logic                   hit;
  logic                   match;
  logic                   report_miss;
  logic [LEN_W-1:0]       len_eff;
  logic [OFFSET_BITS-1:0] count_next;
  logic [OFFSET_BITS-1:0] offset_next;
  byte_row_t              window_next;
  byte_row_t              pattern;
  pat_wr_t                pat_wr;

  // Advance the stage whenever the result register is free or being emptied;
  // the input register refills in the same cycle, so requests flow back to back.
  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;

  assign is_search = (s1.action == ACT_SEARCH);
  // Bytes after a match in the same region are dropped until its last byte.
  assign live      = is_search && !region_done;

  // Lengths beyond the store saturate.
  assign len_eff = (pattern_length > LEN_MAX) ? LEN_MAX : pattern_length;

  // Newest byte enters at entry 0; the oldest falls off the far end.
  assign window_next = byte_row_t'({window[MAX_PATTERN-2:0], s1.byte_value});

  // Byte count saturates rather than wrapping.
  assign count_next = (bytes_seen == OFFSET_MAX) ? bytes_seen : bytes_seen + 1'b1;

  assign pat_wr.en   = advance && (s1.action == ACT_WRITE);
  assign pat_wr.addr = s1.pattern_index;
  assign pat_wr.data = s1.byte_value;

  wbps_pattern_store u_store (
    .clk     (clk),
    .wr      (pat_wr),
    .pattern (pattern)
  );

  wbps_matcher u_matcher (
    .pattern        (pattern),
    .window         (window_next),
    .len            (len_eff),
    .wildcard_value (wildcard_value),
    .hit            (hit)
  );

  // A full match needs at least len bytes in this region; an empty pattern
  // matches on the first byte at offset zero.
  assign match       = live && (count_next >= OFFSET_BITS'(len_eff)) && hit;
  assign report_miss = live && !match && s1.region_last;
  assign offset_next = (len_eff == '0) ? '0 : count_next - OFFSET_BITS'(len_eff);

  // Control and region state
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_RESET;
      wildcard_value <= '0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      window         <= '0;
      bytes_seen     <= '0;
      region_done    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
          CFG_WILDCARD_VALUE: wildcard_value <= cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end

      if (item.ready) begin
        s1_valid <= item.valid;
      end

      if (advance) begin
        out_valid <= match || report_miss;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      // Any search byte that closes a region starts the next one afresh.
      if (advance && is_search) begin
        if (s1.region_last) begin
          window      <= '0;
          bytes_seen  <= '0;
          region_done <= 1'b0;
        end else if (live) begin
          window      <= window_next;
          bytes_seen  <= count_next;
          region_done <= match;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1.action        <= item.action;
      s1.pattern_index <= item.pattern_index;
      s1.byte_value    <= item.byte_value;
      s1.region_last   <= item.region_last;
    end
    if (advance) begin
      out_found  <= match;
      out_offset <= match ? offset_next : '0;
    end
  end

  assign result.valid        = out_valid;
  assign result.found        = out_found;
  assign result.match_offset = out_offset;

  `WBPS_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid && !s1_valid)
  `WBPS_ASSERT(a_done_has_bytes, clk, rst, region_done |-> bytes_seen != '0)
  `WBPS_ASSERT(a_match_sets_done, clk, rst, advance && match && !s1.region_last |=> region_done)
  `WBPS_ASSERT(a_miss_zero_offset, clk, rst, out_valid && !out_found |-> out_offset == '0)

endmodule
